>>> rtl/scd_pkg.sv
// shared widths, constants and stage side-band types for the circumradius pipeline
package scd_pkg;

   localparam int NUM_W  = 57;            // numerator magnitude, scaled by 256
   localparam int DEN_W  = 35;            // denominator magnitude
   localparam int QB     = 25;            // quotient bits resolved by the divider
   localparam int CMP_W  = DEN_W + QB;    // divider compare width
   localparam int RT_W   = 26;            // root bits
   localparam int SQ_W   = 52;            // squared distance width

   localparam logic signed [23:0] CEN_MAX   = 24'sd8388607;
   localparam logic signed [23:0] CEN_MIN   = -24'sd8388608;
   localparam logic signed [25:0] DIST_MAX  = 26'sd33554431;
   localparam logic [QB-1:0]      POS_LIM   = 25'd8388607;
   localparam logic [QB-1:0]      NEG_LIM   = 25'd8388608;

   typedef struct packed {
      logic nx_neg;
      logic ny_neg;
      logic den_neg;
   } num_sign_type;

   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [16:0] a;
      logic signed [16:0] b;
      logic               side_p_neg;
      logic               side_p_pos;
      logic               degen;
   } div_side_type;

   typedef struct packed {
      logic signed [23:0] qx;
      logic signed [23:0] qy;
      logic               degen;
      logic               ovf;
      logic               neg_r;
   } sq_side_type;

endpackage

>>> rtl/scd_if.sv
// request and response channel interfaces
interface scd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] edge_start_x;
   logic signed [15:0] edge_start_y;
   logic signed [15:0] edge_end_x;
   logic signed [15:0] edge_end_y;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;

   modport source (output valid, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
                   point_x, point_y, input ready);
   modport sink (input valid, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
                 point_x, point_y, output ready);
endinterface

interface scd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] center_x;
   logic signed [23:0] center_y;
   logic signed [25:0] distance;
   logic               degenerate;
   logic               overflow;

   modport source (output valid, center_x, center_y, distance, degenerate, overflow,
                   input ready);
   modport sink (input valid, center_x, center_y, distance, degenerate, overflow,
                 output ready);
endinterface

>>> rtl/scd_front.sv
// front end: differences, products and circumcentre numerators, four stages
module scd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic signed [15:0]        ax,
   input  logic signed [15:0]        ay,
   input  logic signed [15:0]        bx,
   input  logic signed [15:0]        by,
   input  logic signed [15:0]        px,
   input  logic signed [15:0]        py,
   output logic                      out_valid,
   output logic [scd_pkg::NUM_W-1:0] nx_mag,
   output logic [scd_pkg::NUM_W-1:0] ny_mag,
   output logic [scd_pkg::DEN_W-1:0] den_mag,
   output scd_pkg::num_sign_type     signs,
   output scd_pkg::div_side_type     side
);
   import scd_pkg::*;

   logic [4:1] v_ff;

   // stage 1
   logic signed [16:0] a_in, b_in, c_in, d_in, sx_in, sy_in, tx_in, ty_in, ux_in, uy_in;
   logic signed [16:0] a1_ff, b1_ff, c1_ff, d1_ff, sx1_ff, sy1_ff, tx1_ff, ty1_ff;
   logic signed [16:0] ux1_ff, uy1_ff;
   logic signed [15:0] ax1_ff, ay1_ff, px1_ff, py1_ff;

   // stage 2
   logic signed [33:0] e_in, f_in;
   logic signed [35:0] g_in, sp_in;
   logic signed [33:0] e2_ff, f2_ff;
   logic signed [35:0] g2_ff;
   logic signed [16:0] a2_ff, b2_ff, c2_ff, d2_ff;
   logic signed [15:0] ax2_ff, ay2_ff, px2_ff, py2_ff;
   logic               spn2_ff, spp2_ff, dg2_ff;

   // stage 3
   logic signed [50:0] nx_in, ny_in;
   logic signed [50:0] nx3_ff, ny3_ff;
   logic signed [35:0] g3_ff;
   div_side_type       side3_ff;

   // stage 4
   logic [50:0]        nxa_in, nya_in;
   logic [35:0]        ga_in;
   logic [NUM_W-1:0]   nx4_ff, ny4_ff;
   logic [DEN_W-1:0]   g4_ff;
   num_sign_type       sg4_ff;
   div_side_type       side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[3:1], in_valid};
      end
   end

   assign a_in  = bx - ax;
   assign b_in  = by - ay;
   assign c_in  = px - ax;
   assign d_in  = py - ay;
   assign sx_in = ax + bx;
   assign sy_in = ay + by;
   assign tx_in = ax + px;
   assign ty_in = ay + py;
   assign ux_in = px - bx;
   assign uy_in = py - by;

   assign e_in  = a1_ff * sx1_ff + b1_ff * sy1_ff;
   assign f_in  = c1_ff * tx1_ff + d1_ff * ty1_ff;
   assign g_in  = (a1_ff * uy1_ff - b1_ff * ux1_ff) <<< 1;
   assign sp_in = b1_ff * c1_ff - a1_ff * d1_ff;

   assign nx_in = d2_ff * e2_ff - b2_ff * f2_ff;
   assign ny_in = a2_ff * f2_ff - c2_ff * e2_ff;

   assign nxa_in = nx3_ff[50] ? 51'(-nx3_ff) : 51'(nx3_ff);
   assign nya_in = ny3_ff[50] ? 51'(-ny3_ff) : 51'(ny3_ff);
   assign ga_in  = g3_ff[35] ? 36'(-g3_ff) : 36'(g3_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= a_in;   b1_ff  <= b_in;   c1_ff  <= c_in;   d1_ff  <= d_in;
         sx1_ff <= sx_in;  sy1_ff <= sy_in;  tx1_ff <= tx_in;  ty1_ff <= ty_in;
         ux1_ff <= ux_in;  uy1_ff <= uy_in;
         ax1_ff <= ax;     ay1_ff <= ay;     px1_ff <= px;     py1_ff <= py;

         e2_ff   <= e_in;
         f2_ff   <= f_in;
         g2_ff   <= g_in;
         spn2_ff <= sp_in[35];
         spp2_ff <= !sp_in[35] && (sp_in != '0);
         dg2_ff  <= (g_in == '0);
         a2_ff <= a1_ff;  b2_ff <= b1_ff;  c2_ff <= c1_ff;  d2_ff <= d1_ff;
         ax2_ff <= ax1_ff; ay2_ff <= ay1_ff; px2_ff <= px1_ff; py2_ff <= py1_ff;

         nx3_ff <= nx_in;
         ny3_ff <= ny_in;
         g3_ff  <= g2_ff;
         side3_ff.px <= px2_ff;
         side3_ff.py <= py2_ff;
         side3_ff.ax <= ax2_ff;
         side3_ff.ay <= ay2_ff;
         side3_ff.a  <= a2_ff;
         side3_ff.b  <= b2_ff;
         side3_ff.side_p_neg <= spn2_ff;
         side3_ff.side_p_pos <= spp2_ff;
         side3_ff.degen      <= dg2_ff;

         // scale by 256 on the way into the divider
         nx4_ff <= {nxa_in[48:0], 8'h00};
         ny4_ff <= {nya_in[48:0], 8'h00};
         g4_ff  <= ga_in[DEN_W-1:0];
         sg4_ff.nx_neg  <= nx3_ff[50];
         sg4_ff.ny_neg  <= ny3_ff[50];
         sg4_ff.den_neg <= g3_ff[35];
         side4_ff <= side3_ff;
      end
   end

   assign out_valid = v_ff[4];
   assign nx_mag    = nx4_ff;
   assign ny_mag    = ny4_ff;
   assign den_mag   = g4_ff;
   assign signs     = sg4_ff;
   assign side      = side4_ff;

endmodule

>>> rtl/scd_div.sv
// pipelined restoring divider, one quotient bit per stage, both centre coordinates
module scd_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [scd_pkg::NUM_W-1:0] nx_mag,
   input  logic [scd_pkg::NUM_W-1:0] ny_mag,
   input  logic [scd_pkg::DEN_W-1:0] den_mag,
   input  scd_pkg::num_sign_type     signs,
   input  scd_pkg::div_side_type     side,
   output logic                      out_valid,
   output logic signed [23:0]        qx,
   output logic signed [23:0]        qy,
   output logic                      ovf,
   output scd_pkg::div_side_type     side_out
);
   import scd_pkg::*;

   logic               v_ff   [0:QB];
   logic [NUM_W-1:0]   rx_ff  [0:QB];
   logic [NUM_W-1:0]   ry_ff  [0:QB];
   logic [QB-1:0]      qx_ff  [0:QB];
   logic [QB-1:0]      qy_ff  [0:QB];
   logic [DEN_W-1:0]   den_ff [0:QB];
   logic               bx_ff  [0:QB];
   logic               by_ff  [0:QB];
   num_sign_type       sg_ff  [0:QB];
   div_side_type       sd_ff  [0:QB];

   logic [CMP_W-1:0]   den_top;
   logic               big_x_in, big_y_in;

   // quotient of 2^25 or more always saturates
   assign den_top  = {den_mag, {QB{1'b0}}};
   assign big_x_in = CMP_W'(nx_mag) >= den_top;
   assign big_y_in = CMP_W'(ny_mag) >= den_top;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff[0]  <= nx_mag;
         ry_ff[0]  <= ny_mag;
         qx_ff[0]  <= '0;
         qy_ff[0]  <= '0;
         den_ff[0] <= den_mag;
         bx_ff[0]  <= big_x_in;
         by_ff[0]  <= big_y_in;
         sg_ff[0]  <= signs;
         sd_ff[0]  <= side;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_bit
      localparam int BIT = QB - k;
      logic [CMP_W-1:0] trial, rxw, ryw;
      logic             hx, hy;

      assign trial = CMP_W'(den_ff[k-1]) << BIT;
      assign rxw   = CMP_W'(rx_ff[k-1]);
      assign ryw   = CMP_W'(ry_ff[k-1]);
      assign hx    = rxw >= trial;
      assign hy    = ryw >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff[k]  <= hx ? NUM_W'(rxw - trial) : rx_ff[k-1];
            ry_ff[k]  <= hy ? NUM_W'(ryw - trial) : ry_ff[k-1];
            qx_ff[k]  <= qx_ff[k-1] | ({{(QB-1){1'b0}}, hx} << BIT);
            qy_ff[k]  <= qy_ff[k-1] | ({{(QB-1){1'b0}}, hy} << BIT);
            den_ff[k] <= den_ff[k-1];
            bx_ff[k]  <= bx_ff[k-1];
            by_ff[k]  <= by_ff[k-1];
            sg_ff[k]  <= sg_ff[k-1];
            sd_ff[k]  <= sd_ff[k-1];
         end
      end
   end

   // sign, saturation and collinear override
   logic               neg_x, neg_y, sat_x, sat_y;
   logic [QB:0]        qxe, qye;
   logic signed [23:0] qx_in, qy_in;
   logic               ovf_in;
   logic               vo_ff;
   logic signed [23:0] qx_ff_o, qy_ff_o;
   logic               ovf_ff;
   div_side_type       so_ff;

   always_comb begin
      neg_x = sg_ff[QB].nx_neg ^ sg_ff[QB].den_neg;
      neg_y = sg_ff[QB].ny_neg ^ sg_ff[QB].den_neg;
      qxe   = {1'b0, qx_ff[QB]};
      qye   = {1'b0, qy_ff[QB]};
      sat_x = bx_ff[QB] || (neg_x ? (qx_ff[QB] > NEG_LIM) : (qx_ff[QB] > POS_LIM));
      sat_y = by_ff[QB] || (neg_y ? (qy_ff[QB] > NEG_LIM) : (qy_ff[QB] > POS_LIM));
      if (sat_x) begin
         qx_in = neg_x ? CEN_MIN : CEN_MAX;
      end else begin
         qx_in = neg_x ? 24'(-qxe) : 24'(qxe);
      end
      if (sat_y) begin
         qy_in = neg_y ? CEN_MIN : CEN_MAX;
      end else begin
         qy_in = neg_y ? 24'(-qye) : 24'(qye);
      end
      ovf_in = sat_x || sat_y;
      if (sd_ff[QB].degen) begin
         qx_in  = '0;
         qy_in  = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= v_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff_o <= qx_in;
         qy_ff_o <= qy_in;
         ovf_ff  <= ovf_in;
         so_ff   <= sd_ff[QB];
      end
   end

   assign out_valid = vo_ff;
   assign qx        = qx_ff_o;
   assign qy        = qy_ff_o;
   assign ovf       = ovf_ff;
   assign side_out  = so_ff;

endmodule

>>> rtl/scd_sqrt.sv
// distance squares, halfspace test and pipelined square root with output register
module scd_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic signed [23:0]    qx,
   input  logic signed [23:0]    qy,
   input  logic                  ovf,
   input  scd_pkg::div_side_type side,
   output logic                  out_valid,
   output logic signed [23:0]    center_x,
   output logic signed [23:0]    center_y,
   output logic signed [25:0]    distance,
   output logic                  degenerate,
   output logic                  overflow
);
   import scd_pkg::*;

   logic [2:1] pv_ff;

   // stage 1: offsets from candidate and from edge start
   logic signed [24:0] dx_in, dy_in, tx_in, ty_in;
   logic signed [24:0] dx1_ff, dy1_ff, tx1_ff, ty1_ff;
   logic signed [16:0] a1_ff, b1_ff;
   logic               spn1_ff, spp1_ff;
   logic signed [23:0] qx1_ff, qy1_ff;
   logic               dg1_ff, ov1_ff;

   // stage 2: products
   logic signed [49:0] dxx2_ff, dyy2_ff;
   logic signed [41:0] btx2_ff, aty2_ff;
   logic               spn2_ff, spp2_ff;
   logic signed [23:0] qx2_ff, qy2_ff;
   logic               dg2_ff, ov2_ff;

   // stage 3: sums and side decision
   logic [SQ_W-1:0]    sq_in;
   logic signed [42:0] sc_in;
   logic               negr_in;

   logic               v_ff  [0:RT_W];
   logic [SQ_W-1:0]    rm_ff [0:RT_W];
   logic [RT_W-1:0]    rt_ff [0:RT_W];
   sq_side_type        sd_ff [0:RT_W];

   assign dx_in = qx - $signed({side.px, 8'h00});
   assign dy_in = qy - $signed({side.py, 8'h00});
   assign tx_in = qx - $signed({side.ax, 8'h00});
   assign ty_in = qy - $signed({side.ay, 8'h00});

   assign sq_in   = {2'b00, dxx2_ff} + {2'b00, dyy2_ff};
   assign sc_in   = btx2_ff - aty2_ff;
   assign negr_in = (spn2_ff && !sc_in[42] && (sc_in != '0)) || (spp2_ff && sc_in[42]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff   <= '0;
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         pv_ff   <= {pv_ff[1], in_valid};
         v_ff[0] <= pv_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff  <= dx_in;   dy1_ff <= dy_in;   tx1_ff <= tx_in;   ty1_ff <= ty_in;
         a1_ff   <= side.a;  b1_ff  <= side.b;
         spn1_ff <= side.side_p_neg;
         spp1_ff <= side.side_p_pos;
         qx1_ff  <= qx;      qy1_ff <= qy;
         dg1_ff  <= side.degen;
         ov1_ff  <= ovf;

         dxx2_ff <= dx1_ff * dx1_ff;
         dyy2_ff <= dy1_ff * dy1_ff;
         btx2_ff <= b1_ff * tx1_ff;
         aty2_ff <= a1_ff * ty1_ff;
         spn2_ff <= spn1_ff; spp2_ff <= spp1_ff;
         qx2_ff  <= qx1_ff;  qy2_ff  <= qy1_ff;
         dg2_ff  <= dg1_ff;  ov2_ff  <= ov1_ff;

         rm_ff[0]       <= sq_in;
         rt_ff[0]       <= '0;
         sd_ff[0].qx    <= qx2_ff;
         sd_ff[0].qy    <= qy2_ff;
         sd_ff[0].degen <= dg2_ff;
         sd_ff[0].ovf   <= ov2_ff;
         sd_ff[0].neg_r <= negr_in;
      end
   end

   // one root bit per stage, largest first
   for (genvar k = 1; k <= RT_W; k++) begin : g_root
      localparam int BIT = RT_W - k;
      logic [SQ_W-1:0] trial;
      logic            hit;

      assign trial = (SQ_W'(rt_ff[k-1]) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
      assign hit   = rm_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rm_ff[k] <= hit ? (rm_ff[k-1] - trial) : rm_ff[k-1];
            rt_ff[k] <= rt_ff[k-1] | ({{(RT_W-1){1'b0}}, hit} << BIT);
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   logic signed [25:0] dist_in;
   logic               vo_ff;
   logic signed [23:0] cx_ff, cy_ff;
   logic signed [25:0] dist_ff;
   logic               dg_ff, ov_ff;

   always_comb begin
      if (sd_ff[RT_W].degen || sd_ff[RT_W].ovf) begin
         dist_in = DIST_MAX;
      end else if (sd_ff[RT_W].neg_r) begin
         dist_in = -$signed(rt_ff[RT_W]);
      end else begin
         dist_in = $signed(rt_ff[RT_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= v_ff[RT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff   <= sd_ff[RT_W].qx;
         cy_ff   <= sd_ff[RT_W].qy;
         dist_ff <= dist_in;
         dg_ff   <= sd_ff[RT_W].degen;
         ov_ff   <= sd_ff[RT_W].ovf;
      end
   end

   assign out_valid  = vo_ff;
   assign center_x   = cx_ff;
   assign center_y   = cy_ff;
   assign distance   = dist_ff;
   assign degenerate = dg_ff;
   assign overflow   = ov_ff;

endmodule

>>> rtl/signed_circumradius_distance.sv
// top level: signed circumradius distance pipeline
// throughput: one beat per cycle unless the response register stalls;
// 25 divider stages and 26 root stages each resolve one bit
// a stalled response register freezes every stage at once, so nothing is dropped or repeated
// reset: synchronous, active high; clears the valid bit of every stage
module signed_circumradius_distance (
   input  logic        clock,
   input  logic        reset,
   scd_req_if.sink     req_ch,
   scd_rsp_if.source   rsp_ch
);
   import scd_pkg::*;

   // whole pipeline moves when the output register is empty or being drained
   logic adv;

   logic             fr_valid;
   logic [NUM_W-1:0] fr_nx, fr_ny;
   logic [DEN_W-1:0] fr_den;
   num_sign_type     fr_signs;
   div_side_type     fr_side;

   logic               dv_valid;
   logic signed [23:0] dv_qx, dv_qy;
   logic               dv_ovf;
   div_side_type       dv_side;

   logic               sq_valid;

   assign adv          = !sq_valid || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = sq_valid;

   // differences, products, numerators and magnitudes
   scd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .ax        (req_ch.edge_start_x),
      .ay        (req_ch.edge_start_y),
      .bx        (req_ch.edge_end_x),
      .by        (req_ch.edge_end_y),
      .px        (req_ch.point_x),
      .py        (req_ch.point_y),
      .out_valid (fr_valid),
      .nx_mag    (fr_nx),
      .ny_mag    (fr_ny),
      .den_mag   (fr_den),
      .signs     (fr_signs),
      .side      (fr_side)
   );

   // truncating divide, saturation to q15.8 and collinear override
   scd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .nx_mag    (fr_nx),
      .ny_mag    (fr_ny),
      .den_mag   (fr_den),
      .signs     (fr_signs),
      .side      (fr_side),
      .out_valid (dv_valid),
      .qx        (dv_qx),
      .qy        (dv_qy),
      .ovf       (dv_ovf),
      .side_out  (dv_side)
   );

   // radius by floor square root, signed by the halfspace test
   scd_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (dv_valid),
      .qx         (dv_qx),
      .qy         (dv_qy),
      .ovf        (dv_ovf),
      .side       (dv_side),
      .out_valid  (sq_valid),
      .center_x   (rsp_ch.center_x),
      .center_y   (rsp_ch.center_y),
      .distance   (rsp_ch.distance),
      .degenerate (rsp_ch.degenerate),
      .overflow   (rsp_ch.overflow)
   );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// testbench for the signed circumradius distance pipeline: random and directed beats, scoreboard
module tb_top;
   import scd_pkg::*;

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
      logic signed [15:0] px;
      logic signed [15:0] py;
   } tri_beat_type;

   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [25:0] radius;
      logic               degen;
      logic               ovf;
   } radius_beat_type;

   logic clock;
   logic reset;

   scd_req_if req_ch ();
   scd_rsp_if rsp_ch ();

   signed_circumradius_distance uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tri_beat_type    pending_tris[$];
   radius_beat_type expected_radii[$];
   bit              stimulus_done;
   int              error_count;
   int              rsp_accepted;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // floor square root, bit by bit
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic int sign_of(input longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // circumcentre and signed radius of one triangle
   function automatic radius_beat_type circumradius(input tri_beat_type t);
      radius_beat_type r;
      longint ax, ay, bx, by, px, py;
      longint da, db, dc, dd, e, f, g, qx, qy, dx, dy, sp, sc, rad;
      longint unsigned sq;
      bit ovf;
      ax = t.sx; ay = t.sy; bx = t.ex; by = t.ey; px = t.px; py = t.py;
      da = bx - ax; db = by - ay;
      dc = px - ax; dd = py - ay;
      e  = da * (ax + bx) + db * (ay + by);
      f  = dc * (ax + px) + dd * (ay + py);
      g  = 2 * (da * (py - by) - db * (px - bx));
      r  = '0;
      if (g == 0) begin
         // collinear: no centre, maximum distance
         r.radius = DIST_MAX;
         r.degen  = 1'b1;
         return r;
      end
      qx  = ((dd * e - db * f) * 256) / g;
      qy  = ((da * f - dc * e) * 256) / g;
      ovf = 1'b0;
      if (qx > CEN_MAX) begin qx = CEN_MAX; ovf = 1'b1; end
      if (qx < CEN_MIN) begin qx = CEN_MIN; ovf = 1'b1; end
      if (qy > CEN_MAX) begin qy = CEN_MAX; ovf = 1'b1; end
      if (qy < CEN_MIN) begin qy = CEN_MIN; ovf = 1'b1; end
      r.cx = qx[23:0];
      r.cy = qy[23:0];
      if (ovf) begin
         r.radius = DIST_MAX;
         r.ovf    = 1'b1;
         return r;
      end
      dx  = qx - px * 256;
      dy  = qy - py * 256;
      sq  = dx * dx + dy * dy;
      rad = longint'(floor_root(sq));
      // halfspace test against the edge normal, centre strictly opposite gives a negative radius
      sp  = db * (px - ax) - da * (py - ay);
      sc  = db * (qx - ax * 256) - da * (qy - ay * 256);
      if (sign_of(sp) * sign_of(sc) < 0) rad = -rad;
      r.radius = rad[25:0];
      return r;
   endfunction

   function automatic tri_beat_type mk_tri(input int sx, sy, ex, ey, px, py);
      tri_beat_type t;
      t.sx = sx[15:0]; t.sy = sy[15:0]; t.ex = ex[15:0];
      t.ey = ey[15:0]; t.px = px[15:0]; t.py = py[15:0];
      return t;
   endfunction

   // append one triangle to the pending queue
   function automatic void add_tri(input tri_beat_type t);
      pending_tris = {pending_tris, t};
   endfunction

   function automatic int near(input int base, input int span);
      int v;
      v = base + $urandom_range(2 * span) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // stimulus: directed corner cases, then random mixes
   initial begin
      tri_beat_type t;
      int mode, bx, by, k, ddx, ddy;
      stimulus_done = 1'b0;
      // all points coincident
      add_tri(mk_tri(0, 0, 0, 0, 0, 0));
      // collinear along a line
      add_tri(mk_tri(0, 0, 10, 10, 20, 20));
      // collinear across the full range
      add_tri(mk_tri(-32768, -32768, 32767, 32767, 0, 0));
      // repeated edge endpoint
      add_tri(mk_tri(5, 7, 5, 7, -100, 3));
      // right triangle: centre on the edge line
      add_tri(mk_tri(0, 0, 10, 0, 5, 5));
      add_tri(mk_tri(-4, 0, 4, 0, 0, -4));
      // acute: centre on the candidate's side
      add_tri(mk_tri(0, 0, 10, 0, 5, 8));
      // obtuse: centre opposite the candidate
      add_tri(mk_tri(0, 0, 100, 0, 50, 3));
      add_tri(mk_tri(0, 0, 100, 0, 50, -3));
      // extreme corners of the field range
      add_tri(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767));
      add_tri(mk_tri(32767, 32767, -32768, 32767, 32767, -32768));
      add_tri(mk_tri(-32768, 32767, 32767, 32767, 0, -32768));
      add_tri(mk_tri(-1, -1, 32767, 0, 0, 32767));
      // nearly collinear far apart: centre saturates
      add_tri(mk_tri(-32768, 0, 32767, 0, 0, 1));
      add_tri(mk_tri(-32768, 0, 32767, 0, 0, -1));
      add_tri(mk_tri(0, -32768, 1, 32767, -1, 0));
      add_tri(mk_tri(-32768, -32768, 32767, 32767, 1, 0));
      // tiny triangles with fractional centres, both signs
      add_tri(mk_tri(0, 0, 1, 0, 0, 1));
      add_tri(mk_tri(0, 0, -1, 0, 0, -1));
      add_tri(mk_tri(1, 2, -3, 5, 7, -2));
      add_tri(mk_tri(-7, 3, 2, -5, -1, -6));
      for (int i = 0; i < 1400; i++) begin
         mode = $urandom_range(9);
         if (mode <= 2) begin
            // full range
            t = mk_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else if (mode <= 6) begin
            // local cluster at a random spot, mostly well-formed triangles
            bx = $signed(16'($urandom));
            by = $signed(16'($urandom));
            k  = (mode == 6) ? 30000 : (mode == 5 ? 2000 : 60);
            t = mk_tri(near(bx, k), near(by, k), near(bx, k), near(by, k),
                       near(bx, k), near(by, k));
         end else if (mode == 7) begin
            // collinear candidate on the edge line
            bx  = $urandom_range(2000) - 1000;
            by  = $urandom_range(2000) - 1000;
            ddx = $urandom_range(200) - 100;
            ddy = $urandom_range(200) - 100;
            k   = $urandom_range(10) - 5;
            t = mk_tri(bx, by, bx + ddx, by + ddy, bx + k * ddx, by + k * ddy);
         end else begin
            // nearly collinear long edge, candidate near its midpoint, on or just off the line
            bx  = $urandom_range(30000);
            by  = $urandom_range(30000);
            t = mk_tri(-bx, -by, bx, by, near(0, 2), near(0, 2));
         end
         add_tri(t);
      end
      stimulus_done = 1'b1;
   end

   // sender: bursts of random length with random gaps
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid        <= 1'b0;
         req_ch.edge_start_x <= '0;
         req_ch.edge_start_y <= '0;
         req_ch.edge_end_x   <= '0;
         req_ch.edge_end_y   <= '0;
         req_ch.point_x      <= '0;
         req_ch.point_y      <= '0;
         burst_left          <= 0;
         gap_left            <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_radii = {expected_radii, circumradius(mk_tri(
               req_ch.edge_start_x, req_ch.edge_start_y, req_ch.edge_end_x,
               req_ch.edge_end_y, req_ch.point_x, req_ch.point_y))};
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 || pending_tris.size() == 0) begin
               req_ch.valid <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
               tri_beat_type t;
               t = pending_tris.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.edge_start_x <= t.sx;
               req_ch.edge_start_y <= t.sy;
               req_ch.edge_end_x   <= t.ex;
               req_ch.edge_end_y   <= t.ey;
               req_ch.point_x      <= t.px;
               req_ch.point_y      <= t.py;
               if (burst_left <= 1) begin
                  // end of burst: pick the next gap and burst length, sometimes no gap
                  burst_left <= $urandom_range(40, 1);
                  gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off to fill the pipeline
   int stall_phase;
   int hold_left;
   bit hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_phase  <= 0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && rsp_accepted >= 300) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 300;
         hold_done    <= 1'b1;
      end else begin
         stall_phase <= (stall_phase + 1) % 97;
         // first third of the pattern never stalls, rest stalls at random
         if (stall_phase < 32) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(3) != 0);
      end
   end

   // monitor: compare each response beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_accepted <= 0;
         error_count  <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         radius_beat_type exp_r;
         rsp_accepted <= rsp_accepted + 1;
         if (expected_radii.size() == 0) begin
            $display("%0t: unexpected response beat cx=%0d cy=%0d dist=%0d",
                     $time, rsp_ch.center_x, rsp_ch.center_y, rsp_ch.distance);
            error_count <= error_count + 1;
         end else begin
            exp_r = expected_radii.pop_front();
            if (rsp_ch.center_x !== exp_r.cx || rsp_ch.center_y !== exp_r.cy ||
                rsp_ch.distance !== exp_r.radius || rsp_ch.degenerate !== exp_r.degen ||
                rsp_ch.overflow !== exp_r.ovf) begin
               $display("%0t: mismatch expected cx=%0d cy=%0d dist=%0d dg=%b ov=%b",
                        $time, exp_r.cx, exp_r.cy, exp_r.radius, exp_r.degen, exp_r.ovf);
               $display("%0t:          actual   cx=%0d cy=%0d dist=%0d dg=%b ov=%b",
                        $time, rsp_ch.center_x, rsp_ch.center_y, rsp_ch.distance,
                        rsp_ch.degenerate, rsp_ch.overflow);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // end of run: wait for every expected response, then keep watching for stray beats
   initial begin
      @(negedge reset);
      wait (stimulus_done && pending_tris.size() == 0 && !req_ch.valid);
      wait (expected_radii.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_radii.size() == 0) begin
         $display("PASS signed_circumradius_distance");
      end else begin
         $display("FAIL signed_circumradius_distance");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("FAIL signed_circumradius_distance");
      $finish;
   end

endmodule
